// ===== sv/imu6_pkg.sv =====
// Package for the six-axis IMU conditioner: payload structs, codes and constants.
// No dependencies.
package imu6_pkg;

  localparam int unsigned Axes = 6;
  localparam int unsigned MaxCalSamples = 1024;
  localparam int unsigned CntW = $clog2(MaxCalSamples + 1);
  localparam int unsigned SumW = 32 + CntW;
  localparam logic signed [31:0] GravityQ16 = 32'sd642908;
  localparam logic [16:0] OneQ16 = 17'd65536;

  typedef enum logic [1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_CAL_START = 2'd1,
    FUNC_CAL_SAMPLE = 2'd2,
    FUNC_CAL_FINISH = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_READ_FAIL = 2'd1,
    ST_DEV_ERR = 2'd2,
    ST_NO_SAMPLES = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MODE_READY = 2'd0,
    MODE_CAL = 2'd1,
    MODE_ERROR = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    REG_ALPHA = 2'd0,
    REG_ACCEL_SCALE = 2'd1,
    REG_GYRO_SCALE = 2'd2
  } reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILT_A,
    S_FILT_B,
    S_DIV,
    S_SCALE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0] func;
    logic read_ok;
    logic signed [31:0] acc_x_in;
    logic signed [31:0] acc_y_in;
    logic signed [31:0] acc_z_in;
    logic signed [31:0] rot_x_in;
    logic signed [31:0] rot_y_in;
    logic signed [31:0] rot_z_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic signed [15:0] out_acc_x;
    logic signed [15:0] out_acc_y;
    logic signed [15:0] out_acc_z;
    logic signed [15:0] out_rot_x;
    logic signed [15:0] out_rot_y;
    logic signed [15:0] out_rot_z;
    logic is_calibrated;
    logic [31:0] good_reads;
    logic [31:0] failed_reads;
  } out_item_t;

  // Control handed to the divider.
  typedef struct packed {
    logic start;
    logic signed [SumW-1:0] dividend;
    logic [CntW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic signed [SumW-1:0] quotient;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [SumW+17:0] v);
    if (v > $signed({{(SumW-14){1'b0}}, 32'h7fffffff})) return 32'sh7fffffff;
    if (v < -$signed({{(SumW-14){1'b0}}, 32'h80000000})) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

// ===== sv/imu6_div.sv =====
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on imu6_pkg.
module imu6_div (
  input  logic clk_i,
  input  logic rst_ni,
  input  imu6_pkg::div_req_t req_i,
  output imu6_pkg::div_rsp_t rsp_o
);
  import imu6_pkg::*;

  localparam int unsigned BitW = $clog2(SumW + 1);

  logic [SumW-1:0] quo_q, quo_d;
  logic [CntW:0] rem_q, rem_d;
  logic [BitW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, neg_q, neg_d, done_q, done_d;
  logic [CntW-1:0] dvs_q, dvs_d;
  logic [CntW:0] trial;

  // Shift-subtract restoring step.
  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    neg_d = neg_q;
    dvs_d = dvs_q;
    done_d = 1'b0;
    trial = {rem_q[CntW-1:0], quo_q[SumW-1]};
    if (req_i.start) begin
      neg_d = req_i.dividend[SumW-1];
      quo_d = req_i.dividend[SumW-1] ? (~req_i.dividend + 1'b1) : req_i.dividend;
      rem_d = '0;
      dvs_d = req_i.divisor;
      cnt_d = BitW'(SumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = trial - {1'b0, dvs_q};
        quo_d = {quo_q[SumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[SumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == BitW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quotient = neg_q ? $signed(~quo_q + 1'b1) : $signed(quo_q);

  // A finish result never follows a start directly.
  assert property (@(posedge clk_i) disable iff (!rst_ni) req_i.start |=> !done_q)
    else $error("divider done right after start");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q)
    else $error("divider busy while done");
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |-> cnt_q != '0)
    else $error("divider count underflow");
endmodule

// ===== sv/imu_six_axis_conditioner_unit.sv =====
// Top level of the six-axis IMU conditioner: sequencer, shared multiplier, state.
// Depends on imu6_pkg and imu6_div.
//
//  channel | direction | signals
//  input   | in        | in_valid_i, in_stall_o, in_item_i
//  output  | out       | out_valid_o, out_stall_i, out_item_o
//  config  | in        | cfg_we_i, cfg_idx_i, cfg_data_i
//
// A filtered sample takes two products per axis in the shared multiplier
// (S_FILT_A, S_FILT_B); a sample in ready mode then gets output scaling in
// S_SCALE, and S_DONE finishes. The first sample only seeds the filter.
// Other items go straight to S_DONE. A calibration finish runs the serial
// divider once per axis in S_DIV, then S_DONE.
// Reset clears control state, filter, offsets and sums, not datapath registers.
// A waiting result in the output register holds the next item off until taken.
module imu_six_axis_conditioner_unit (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  imu6_pkg::in_item_t in_item_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output imu6_pkg::out_item_t out_item_o,
  input  logic cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [23:0] cfg_data_i
);
  import imu6_pkg::*;

  state_e state_q, state_d;
  logic [2:0] ax_q, ax_d;
  in_item_t in_q;
  logic [16:0] alpha_q;
  logic [23:0] ascale_q, gscale_q;
  logic signed [31:0] filt_q [Axes];
  logic signed [31:0] offs_q [Axes];
  logic signed [SumW-1:0] sums_q [Axes];
  logic signed [49:0] acc_q;
  logic [CntW-1:0] ccount_q;
  logic seeded_q, calflag_q;
  mode_e mode_q;
  logic [31:0] good_q, fail_q;
  logic [1:0] status_q;
  logic emit_q, sum_en_q;
  logic signed [15:0] res_q [Axes];
  logic ovalid_q;
  div_req_t dreq;
  div_rsp_t drsp;

  logic accept, run_filter, cal_start, cal_finish, empty_cal;
  logic [16:0] a_eff;
  logic signed [31:0] raw, mul_a;
  logic signed [24:0] mul_b;
  logic signed [56:0] prod;
  logic signed [49:0] acc_sum;
  logic signed [31:0] corr_now, filt_new;
  logic signed [15:0] scaled;
  logic [2:0] src_ax;
  logic last_ax;

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE) || ovalid_q;
  assign a_eff = (alpha_q > OneQ16) ? OneQ16 : alpha_q;
  assign last_ax = (ax_q == 3'(Axes - 1));

  // Item decode, evaluated on the accepted item.
  always_comb begin
    run_filter = 1'b0;
    cal_start = 1'b0;
    cal_finish = 1'b0;
    empty_cal = 1'b0;
    if (mode_q != MODE_ERROR) begin
      case (in_item_i.func)
        FUNC_SAMPLE: run_filter = in_item_i.read_ok;
        FUNC_CAL_SAMPLE: run_filter = in_item_i.read_ok && mode_q == MODE_CAL;
        FUNC_CAL_START: cal_start = mode_q == MODE_READY;
        FUNC_CAL_FINISH: begin
          cal_finish = mode_q == MODE_CAL && ccount_q != '0;
          empty_cal = mode_q == MODE_CAL && ccount_q == '0;
        end
        default: ;
      endcase
    end
  end

  // Raw reading of the current axis.
  always_comb begin
    case (ax_q)
      3'd0: raw = in_q.acc_x_in;
      3'd1: raw = in_q.acc_y_in;
      3'd2: raw = in_q.acc_z_in;
      3'd3: raw = in_q.rot_x_in;
      3'd4: raw = in_q.rot_y_in;
      default: raw = in_q.rot_z_in;
    endcase
    corr_now = sat32((SumW+18)'(raw) - (SumW+18)'(offs_q[ax_q]));
  end

  // Output lane ax takes the filtered axis remapped y,z,x.
  always_comb begin
    case (ax_q)
      3'd0: src_ax = 3'd1;
      3'd1: src_ax = 3'd2;
      3'd2: src_ax = 3'd0;
      3'd3: src_ax = 3'd4;
      3'd4: src_ax = 3'd5;
      default: src_ax = 3'd3;
    endcase
  end

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = filt_q[src_ax];
    mul_b = (ax_q < 3'd3) ? $signed({1'b0, ascale_q}) : $signed({1'b0, gscale_q});
    case (state_q)
      S_FILT_A: begin
        mul_a = corr_now;
        mul_b = 25'(a_eff);
      end
      S_FILT_B: begin
        mul_a = filt_q[ax_q];
        mul_b = 25'(OneQ16 - a_eff);
      end
      default: ;
    endcase
  end
  assign prod = mul_a * mul_b;
  assign acc_sum = acc_q + 50'(prod);
  assign filt_new = sat32((SumW+18)'(acc_sum >>> 16));

  // Truncation toward zero of f*scale/2^24 and int16 saturation.
  always_comb begin
    logic signed [56:0] q;
    q = (prod < 0) ? -((-prod) >>> 24) : (prod >>> 24);
    if (q > 57'sd32767) scaled = 16'sh7fff;
    else if (q < -57'sd32768) scaled = 16'sh8000;
    else scaled = q[15:0];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    ax_d = ax_q;
    case (state_q)
      S_IDLE: begin
        ax_d = '0;
        if (accept) begin
          if (run_filter) state_d = S_FILT_A;
          else if (cal_finish) state_d = S_DIV;
          else state_d = S_DONE;
        end
      end
      S_FILT_A: state_d = seeded_q ? S_FILT_B : S_FILT_A;
      S_FILT_B: state_d = S_FILT_A;
      S_DIV: if (drsp.done && last_ax) state_d = S_DONE;
      S_SCALE: if (last_ax) state_d = S_DONE;
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    if ((state_q == S_FILT_A && !seeded_q) || state_q == S_FILT_B) begin
      ax_d = ax_q + 1'b1;
      if (last_ax) begin
        ax_d = '0;
        state_d = emit_q ? S_SCALE : S_DONE;
      end
    end else if (state_q == S_DIV && drsp.done) begin
      ax_d = ax_q + 1'b1;
    end else if (state_q == S_SCALE) begin
      ax_d = ax_q + 1'b1;
    end
  end

  // Divider start pulses.
  always_comb begin
    dreq.start = (state_q == S_IDLE && accept && cal_finish) ||
                 (state_q == S_DIV && drsp.done && !last_ax);
    dreq.dividend = (state_q == S_IDLE) ? sums_q[0] : sums_q[ax_q + 3'd1];
    dreq.divisor = ccount_q;
  end

  imu6_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ax_q <= '0;
      alpha_q <= 17'd26214;
      ascale_q <= 24'd204800;
      gscale_q <= 24'd307200;
      seeded_q <= 1'b0;
      calflag_q <= 1'b0;
      mode_q <= MODE_READY;
      good_q <= '0;
      fail_q <= '0;
      ccount_q <= '0;
      ovalid_q <= 1'b0;
      for (int i = 0; i < Axes; i++) begin
        filt_q[i] <= '0;
        offs_q[i] <= '0;
        sums_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      ax_q <= ax_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ALPHA: alpha_q <= cfg_data_i[16:0];
          REG_ACCEL_SCALE: ascale_q <= cfg_data_i;
          REG_GYRO_SCALE: gscale_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_o && !out_stall_i) ovalid_q <= 1'b0;
      if (state_q == S_DONE) ovalid_q <= 1'b1;
      if (accept) begin
        if (mode_q == MODE_ERROR) begin
          if (in_item_i.func == FUNC_SAMPLE || in_item_i.func == FUNC_CAL_SAMPLE)
            fail_q <= fail_q + 1'b1;
        end else if ((in_item_i.func == FUNC_SAMPLE ||
                      (in_item_i.func == FUNC_CAL_SAMPLE && mode_q == MODE_CAL)) &&
                     !in_item_i.read_ok) begin
          fail_q <= fail_q + 1'b1;
        end
        if (run_filter) good_q <= good_q + 1'b1;
        if (run_filter && in_item_i.func == FUNC_CAL_SAMPLE &&
            ccount_q < CntW'(MaxCalSamples))
          ccount_q <= ccount_q + 1'b1;
        if (cal_start) begin
          mode_q <= MODE_CAL;
          calflag_q <= 1'b0;
          ccount_q <= '0;
          for (int i = 0; i < Axes; i++) begin
            offs_q[i] <= '0;
            sums_q[i] <= '0;
          end
        end
        if (empty_cal) mode_q <= MODE_ERROR;
      end
      // Filter update and calibration sums per axis.
      if (state_q == S_FILT_A) begin
        if (!seeded_q) begin
          filt_q[ax_q] <= corr_now;
          if (last_ax) seeded_q <= 1'b1;
        end
        if (sum_en_q) sums_q[ax_q] <= sums_q[ax_q] + SumW'(corr_now);
      end
      if (state_q == S_FILT_B) filt_q[ax_q] <= filt_new;
      if (state_q == S_DIV && drsp.done) begin
        if (ax_q == 3'd2)
          offs_q[ax_q] <= sat32((SumW+18)'(drsp.quotient) - (SumW+18)'(GravityQ16));
        else
          offs_q[ax_q] <= sat32((SumW+18)'(drsp.quotient));
        if (last_ax) begin
          calflag_q <= 1'b1;
          mode_q <= MODE_READY;
        end
      end
    end
  end

  // Item payload and datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_item_i;
      emit_q <= run_filter && in_item_i.func == FUNC_SAMPLE && mode_q == MODE_READY;
      sum_en_q <= run_filter && in_item_i.func == FUNC_CAL_SAMPLE &&
                  ccount_q < CntW'(MaxCalSamples);
      if (mode_q == MODE_ERROR) status_q <= ST_DEV_ERR;
      else if (empty_cal) status_q <= ST_NO_SAMPLES;
      else if (in_item_i.func == FUNC_CAL_START) status_q <= cal_start ? ST_OK : ST_DEV_ERR;
      else if (in_item_i.func == FUNC_CAL_FINISH) status_q <= cal_finish ? ST_OK : ST_DEV_ERR;
      else if (in_item_i.func == FUNC_CAL_SAMPLE && mode_q != MODE_CAL) status_q <= ST_DEV_ERR;
      else if (!in_item_i.read_ok) status_q <= ST_READ_FAIL;
      else if (in_item_i.func == FUNC_SAMPLE && mode_q == MODE_CAL) status_q <= ST_DEV_ERR;
      else status_q <= ST_OK;
      for (int i = 0; i < Axes; i++) res_q[i] <= '0;
    end
    if (state_q == S_FILT_A) begin
      acc_q <= 50'(prod);
    end
    if (state_q == S_SCALE) res_q[ax_q] <= scaled;
  end

  assign out_valid_o = ovalid_q;
  assign out_item_o.status = status_q;
  assign out_item_o.out_acc_x = res_q[0];
  assign out_item_o.out_acc_y = res_q[1];
  assign out_item_o.out_acc_z = res_q[2];
  assign out_item_o.out_rot_x = res_q[3];
  assign out_item_o.out_rot_y = res_q[4];
  assign out_item_o.out_rot_z = res_q[5];
  assign out_item_o.is_calibrated = calflag_q;
  assign out_item_o.good_reads = good_q;
  assign out_item_o.failed_reads = fail_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o)
    else $error("input taken while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != S_IDLE)
    else $error("item not processed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ccount_q <= CntW'(MaxCalSamples))
    else $error("calibration count beyond bound");
endmodule

// ===== test/tb_top.sv =====
// Testbench for the six-axis IMU conditioner: drives items through the valid/stall
// channels, predicts each result with a behavioral model and compares field by field.
// Depends on imu6_pkg and imu_six_axis_conditioner_unit.
module tb_top;
  import imu6_pkg::*;

  localparam int unsigned StallLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_item_o;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [23:0] cfg_data_i = '0;

  imu_six_axis_conditioner_unit dut (.*);

  // Clock with a period of two time units.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Model state and register copies.
  logic [16:0] m_alpha;
  logic [23:0] m_acc_scale, m_gyr_scale;
  logic signed [31:0] m_filt [Axes];
  logic signed [31:0] m_ofs [Axes];
  logic signed [63:0] m_sum [Axes];
  logic m_seeded, m_cal_flag;
  int unsigned m_cal_cnt;
  mode_e m_mode;
  logic [31:0] m_good, m_bad;

  out_item_t expected_q [$];
  int unsigned err_count = 0;
  int unsigned send_idle_pct = 0, recv_idle_pct = 0;
  bit hold_off = 1'b0;
  int unsigned quiet_cycles = 0;

  function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Scale by an unsigned Q0.24 factor, truncate toward zero and clip to int16.
  function automatic logic signed [15:0] scale_axis(input logic signed [31:0] f,
                                                    input logic [23:0] s);
    logic signed [63:0] p;
    p = 64'(f) * $signed({40'd0, s});
    p = p / 64'sd16777216;
    if (p > 64'sd32767) return 16'sh7fff;
    if (p < -64'sd32768) return 16'sh8000;
    return p[15:0];
  endfunction

  function automatic void model_reset();
    m_alpha = 17'd26214; m_acc_scale = 24'd204800; m_gyr_scale = 24'd307200;
    for (int i = 0; i < Axes; i++) begin
      m_filt[i] = '0; m_ofs[i] = '0; m_sum[i] = '0;
    end
    m_seeded = 1'b0; m_cal_flag = 1'b0; m_cal_cnt = 0;
    m_mode = MODE_READY; m_good = '0; m_bad = '0;
  endfunction

  // Offset removal and EMA update; returns corrected readings.
  function automatic void absorb_reading(input in_item_t it,
                                         output logic signed [31:0] corr [Axes]);
    logic signed [31:0] raw [Axes];
    logic signed [63:0] a, s;
    raw = '{it.acc_x_in, it.acc_y_in, it.acc_z_in, it.rot_x_in, it.rot_y_in, it.rot_z_in};
    a = (m_alpha > 17'd65536) ? 64'sd65536 : 64'($unsigned(m_alpha));
    for (int i = 0; i < Axes; i++) begin
      corr[i] = clip32(64'(raw[i]) - 64'(m_ofs[i]));
      if (!m_seeded) begin
        m_filt[i] = corr[i];
      end else begin
        s = a * 64'(corr[i]) + (64'sd65536 - a) * 64'(m_filt[i]);
        m_filt[i] = clip32(s >>> 16);
      end
    end
    m_seeded = 1'b1;
    m_good++;
  endfunction

  function automatic out_item_t predict_item(input in_item_t it);
    out_item_t r;
    logic signed [31:0] corr [Axes];
    logic signed [63:0] m;
    logic emit;
    func_e f;
    r = '0; emit = 1'b0; f = func_e'(it.func);
    r.status = ST_OK;
    if (m_mode == MODE_ERROR) begin
      r.status = ST_DEV_ERR;
      if (f == FUNC_SAMPLE || f == FUNC_CAL_SAMPLE) m_bad++;
    end else if (f == FUNC_SAMPLE || f == FUNC_CAL_SAMPLE) begin
      if (f == FUNC_CAL_SAMPLE && m_mode != MODE_CAL) begin
        r.status = ST_DEV_ERR;
      end else if (!it.read_ok) begin
        m_bad++; r.status = ST_READ_FAIL;
      end else begin
        absorb_reading(it, corr);
        if (f == FUNC_SAMPLE) begin
          if (m_mode == MODE_READY) emit = 1'b1;
          else r.status = ST_DEV_ERR;
        end else if (m_cal_cnt < MaxCalSamples) begin
          for (int i = 0; i < Axes; i++) m_sum[i] += 64'(corr[i]);
          m_cal_cnt++;
        end
      end
    end else if (f == FUNC_CAL_START) begin
      if (m_mode != MODE_READY) begin
        r.status = ST_DEV_ERR;
      end else begin
        m_mode = MODE_CAL;
        for (int i = 0; i < Axes; i++) begin
          m_ofs[i] = '0; m_sum[i] = '0;
        end
        m_cal_cnt = 0; m_cal_flag = 1'b0;
      end
    end else begin
      if (m_mode != MODE_CAL) begin
        r.status = ST_DEV_ERR;
      end else if (m_cal_cnt == 0) begin
        m_mode = MODE_ERROR; r.status = ST_NO_SAMPLES;
      end else begin
        for (int i = 0; i < Axes; i++) begin
          m = m_sum[i] / $signed(64'(m_cal_cnt));
          if (i == 2) m -= 64'(GravityQ16);
          m_ofs[i] = clip32(m);
        end
        m_cal_flag = 1'b1; m_mode = MODE_READY;
      end
    end
    if (emit) begin
      r.out_acc_x = scale_axis(m_filt[1], m_acc_scale);
      r.out_acc_y = scale_axis(m_filt[2], m_acc_scale);
      r.out_acc_z = scale_axis(m_filt[0], m_acc_scale);
      r.out_rot_x = scale_axis(m_filt[4], m_gyr_scale);
      r.out_rot_y = scale_axis(m_filt[5], m_gyr_scale);
      r.out_rot_z = scale_axis(m_filt[3], m_gyr_scale);
    end
    r.is_calibrated = m_cal_flag;
    r.good_reads = m_good;
    r.failed_reads = m_bad;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    err_count++;
  endtask

  // Receiver: random stall, long hold-off on request, and result checking.
  always @(negedge clk_i) begin
    if (hold_off) out_stall_i <= 1'b1;
    else out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    out_item_t w;
    if (rst_ni && (in_valid_i && !in_stall_o || out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected item", '0, '0);
      end else begin
        w = expected_q.pop_front();
        if (out_item_o.status !== w.status) report_mismatch("status", out_item_o.status, w.status);
        if (out_item_o.out_acc_x !== w.out_acc_x)
          report_mismatch("out_acc_x", out_item_o.out_acc_x, w.out_acc_x);
        if (out_item_o.out_acc_y !== w.out_acc_y)
          report_mismatch("out_acc_y", out_item_o.out_acc_y, w.out_acc_y);
        if (out_item_o.out_acc_z !== w.out_acc_z)
          report_mismatch("out_acc_z", out_item_o.out_acc_z, w.out_acc_z);
        if (out_item_o.out_rot_x !== w.out_rot_x)
          report_mismatch("out_rot_x", out_item_o.out_rot_x, w.out_rot_x);
        if (out_item_o.out_rot_y !== w.out_rot_y)
          report_mismatch("out_rot_y", out_item_o.out_rot_y, w.out_rot_y);
        if (out_item_o.out_rot_z !== w.out_rot_z)
          report_mismatch("out_rot_z", out_item_o.out_rot_z, w.out_rot_z);
        if (out_item_o.is_calibrated !== w.is_calibrated)
          report_mismatch("is_calibrated", out_item_o.is_calibrated, w.is_calibrated);
        if (out_item_o.good_reads !== w.good_reads)
          report_mismatch("good_reads", out_item_o.good_reads, w.good_reads);
        if (out_item_o.failed_reads !== w.failed_reads)
          report_mismatch("failed_reads", out_item_o.failed_reads, w.failed_reads);
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk_i) begin
    if (quiet_cycles >= StallLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Send one item; prediction is made when the item is accepted. The block
  // stalls after each item, so the leading wait costs nothing.
  task automatic send_item(input in_item_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_q.push_back(predict_item(it));
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (400) @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_e idx, input logic [23:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_ALPHA: m_alpha = val[16:0];
      REG_ACCEL_SCALE: m_acc_scale = val;
      default: m_gyr_scale = val;
    endcase
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_axis();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom();
      default: return 32'($signed($urandom_range(1310720))) - 32'sd655360;
    endcase
  endfunction

  function automatic in_item_t make_item(input func_e f, input logic ok);
    in_item_t it;
    it.func = f; it.read_ok = ok;
    it.acc_x_in = rand_axis(); it.acc_y_in = rand_axis(); it.acc_z_in = rand_axis();
    it.rot_x_in = rand_axis(); it.rot_y_in = rand_axis(); it.rot_z_in = rand_axis();
    return it;
  endfunction

  // Extremes, every function, wrong-mode, failed read and calibration paths.
  task automatic test_directed();
    in_item_t it;
    it = '{func: FUNC_SAMPLE, read_ok: 1'b1, acc_x_in: 32'h7fffffff,
           acc_y_in: 32'h80000000, acc_z_in: 32'h7fffffff, rot_x_in: 32'h80000000,
           rot_y_in: 32'h7fffffff, rot_z_in: 32'h80000000};
    send_item(it);
    send_item(~it | 35'h0);
    it.func = FUNC_SAMPLE; it.read_ok = 1'b1;
    it.acc_x_in = 0; it.acc_y_in = -1; it.acc_z_in = 1;
    send_item(it);
    send_item(make_item(FUNC_SAMPLE, 1'b0));
    send_item(make_item(FUNC_CAL_SAMPLE, 1'b1));
    send_item(make_item(FUNC_CAL_FINISH, 1'b1));
    send_item(make_item(FUNC_CAL_START, 1'b1));
    send_item(make_item(FUNC_CAL_START, 1'b0));
    send_item(make_item(FUNC_SAMPLE, 1'b1));
    send_item(make_item(FUNC_CAL_SAMPLE, 1'b0));
    for (int i = 0; i < 4; i++) send_item(make_item(FUNC_CAL_SAMPLE, 1'b1));
    send_item(make_item(FUNC_CAL_FINISH, 1'b0));
    send_item(make_item(FUNC_SAMPLE, 1'b1));
    send_item(make_item(FUNC_SAMPLE, 1'b1));
    drain();
  endtask

  // Register extremes: alpha zero, one and above one; scale minimum and maximum.
  task automatic test_registers();
    logic [23:0] alphas [4] = '{24'd0, 24'd65536, 24'd131071, 24'd1};
    for (int k = 0; k < 4; k++) begin
      write_reg(REG_ALPHA, alphas[k]);
      write_reg(REG_ACCEL_SCALE, k[0] ? 24'hffffff : 24'd1);
      write_reg(REG_GYRO_SCALE, k[0] ? 24'd1 : 24'hffffff);
      for (int i = 0; i < 5; i++) send_item(make_item(FUNC_SAMPLE, 1'b1));
      drain();
    end
    write_reg(REG_ALPHA, 24'd26214);
    write_reg(REG_ACCEL_SCALE, 24'd204800);
    write_reg(REG_GYRO_SCALE, 24'd307200);
  endtask

  // Mostly well-formed calibrations and sample bursts, with some noise.
  task automatic random_burst(input int unsigned n);
    int unsigned cnt;
    for (int unsigned done = 0; done < n;) begin
      if ($urandom_range(3) == 0) begin
        send_item(make_item(FUNC_CAL_START, 1'($urandom_range(1))));
        cnt = $urandom_range(1, 6);
        for (int i = 0; i < cnt; i++)
          send_item(make_item($urandom_range(5) == 0 ? FUNC_SAMPLE : FUNC_CAL_SAMPLE,
                              $urandom_range(9) != 0));
        send_item(make_item(FUNC_CAL_FINISH, 1'($urandom_range(1))));
        done += cnt + 2;
      end else begin
        send_item(make_item(func_e'($urandom_range(9) < 8 ? 0 : $urandom_range(3)),
                            $urandom_range(9) != 0));
        done++;
      end
    end
    drain();
  endtask

  task automatic test_random();
    send_idle_pct = 32; recv_idle_pct = 49;
    write_reg(REG_ALPHA, 24'($urandom_range(65536)));
    random_burst(200);
    send_idle_pct = 49; recv_idle_pct = 32;
    write_reg(REG_ACCEL_SCALE, 24'($urandom_range(1, 24'hffffff)));
    write_reg(REG_GYRO_SCALE, 24'($urandom_range(1, 24'h3ffff)));
    random_burst(200);
    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(REG_ALPHA, 24'd26214);
    random_burst(200);
  endtask

  // Receiver holds off while items keep coming, so the input stalls.
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(negedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 10; i++) send_item(make_item(FUNC_SAMPLE, 1'b1));
    join
    drain();
  endtask

  // Calibration with an empty set latches the error mode; run it last.
  task automatic test_error_mode();
    send_item(make_item(FUNC_CAL_START, 1'b1));
    send_item(make_item(FUNC_CAL_FINISH, 1'b1));
    for (int i = 0; i < 4; i++) send_item(make_item(func_e'(i), 1'b1));
    drain();
  endtask

  initial begin
    model_reset();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_registers();
    test_backpressure();
    test_random();
    test_error_mode();
    if (err_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
